// ----- rtl/core/tpid_pkg.sv -----
// Shared types and constants for the three-axis PID unit.
`timescale 1ns / 1ps

package tpid_pkg;

  localparam int AXES    = 3;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 20;
  localparam int CFG_W   = 3 * GAIN_W;
  localparam int CFG_IDX_W = 2;

  localparam int WINDOW_DEPTH_DEF  = 5;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAINS_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_ROT = 2'd2;

  localparam logic [CFG_W-1:0] GAINS_X_RESET   = 60'd21617498800525148;
  localparam logic [CFG_W-1:0] GAINS_Y_RESET   = 60'd7206199345811292;
  localparam logic [CFG_W-1:0] GAINS_ROT_RESET = 60'd5044559382840607;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // step strobes from the sequencer, shared by all lanes
  typedef struct packed {
    logic load;
    logic clear;
    logic mean;
    logic prop;
    logic integ;
    logic deriv;
  } lane_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat_data = 32'h7fff_ffff;
    end else if (v < lo) begin
      sat_data = 32'h8000_0000;
    end else begin
      sat_data = v[DATA_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/tpid_lane.sv -----
// One axis lane: moving-average window and PID terms through one shared multiplier.
`timescale 1ns / 1ps

module tpid_lane #(
  parameter int WINDOW_DEPTH  = tpid_pkg::WINDOW_DEPTH_DEF,
  parameter int FRACTION_BITS = tpid_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tpid_pkg::lane_ctrl_t                ctrl,
  input  logic [$clog2(WINDOW_DEPTH)-1:0]     slot,
  input  logic signed [tpid_pkg::DATA_W-1:0]  err,
  input  logic [tpid_pkg::CFG_W-1:0]          gains,
  output logic signed [tpid_pkg::DATA_W-1:0]  corr
);

  localparam int DW       = tpid_pkg::DATA_W;
  localparam int GW       = tpid_pkg::GAIN_W;
  localparam int A_W      = DW + $clog2(WINDOW_DEPTH);
  localparam int B_W      = (FRACTION_BITS > GW) ? FRACTION_BITS : GW;
  localparam int P_W      = A_W + B_W;
  localparam int SH_W     = P_W - FRACTION_BITS;
  localparam int TOT_W    = SH_W + 2;
  localparam int RECIP_INT = (1 << FRACTION_BITS) / WINDOW_DEPTH;

  logic signed [DW-1:0]    window [WINDOW_DEPTH];
  logic signed [A_W-1:0]   sum_q;
  logic signed [DW-1:0]    acc_q;
  logic signed [DW-1:0]    prev_q;
  logic signed [DW-1:0]    err_q;
  logic signed [DW-1:0]    mean_q;
  logic signed [DW:0]      diff_q;
  logic signed [TOT_W-1:0] total_q;

  logic signed [A_W-1:0]   op_a;
  logic signed [B_W-1:0]   op_b;
  logic signed [P_W-1:0]   prod;
  logic signed [SH_W-1:0]  prod_sh;
  logic signed [TOT_W-1:0] total_next;

  always_comb begin
    op_a = sum_q;
    op_b = B_W'(RECIP_INT);
    if (ctrl.prop) begin
      op_a = A_W'(mean_q);
      op_b = B_W'($signed(gains[GW-1:0]));
    end else if (ctrl.integ) begin
      op_a = A_W'(acc_q);
      op_b = B_W'($signed(gains[2*GW-1:GW]));
    end else if (ctrl.deriv) begin
      op_a = A_W'(diff_q);
      op_b = B_W'($signed(gains[3*GW-1:2*GW]));
    end
  end

  assign prod       = op_a * op_b;
  assign prod_sh    = prod[P_W-1:FRACTION_BITS];
  assign total_next = total_q + TOT_W'(prod_sh);
  assign corr       = tpid_pkg::sat_data(64'(total_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= '0;
      end
      sum_q  <= '0;
      acc_q  <= '0;
      prev_q <= '0;
    end else begin
      if (ctrl.load) begin
        window[slot] <= err;
        sum_q        <= sum_q - A_W'(window[slot]) + A_W'(err);
      end
      if (ctrl.clear) begin
        acc_q  <= '0;
        prev_q <= '0;
      end
      if (ctrl.prop) begin
        prev_q <= mean_q;
      end
      if (ctrl.integ) begin
        acc_q <= tpid_pkg::sat_data(64'(acc_q) + 64'(err_q));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      err_q <= err;
    end
    if (ctrl.mean) begin
      mean_q <= tpid_pkg::sat_data(64'(prod_sh));
    end
    if (ctrl.prop) begin
      diff_q  <= (DW+1)'(mean_q) - (DW+1)'(prev_q);
      total_q <= TOT_W'(prod_sh);
    end
    if (ctrl.integ || ctrl.deriv) begin
      total_q <= total_next;
    end
  end

endmodule

// ----- rtl/core/three_axis_pid_with_moving_average_unit.sv -----
// Top level: sequencer, gain registers, three axis lanes and merged output register.
//
// Usage:
//   s_axis carries one request per sample: tuser[0] = op (0 sample, 1 clear),
//   tdata = x_error, y_error, rot_error (signed Q16.16, 32 bits each).
//   m_axis returns one result per request: tuser[0] = valid_res, tdata =
//   x, y, rot corrections, saturated; zero for a clear and while the window has not filled.
//   Gains are written on cfg_we/cfg_index/cfg_data while the unit is idle.
// Sequencing:
//   An accepted sample steps through the mean, P, I and D states to the output
//   register: each lane runs its one multiplier four times in sequence (mean,
//   P, I, D terms). A new request is taken in the cycle the previous result is
//   loaded, once the output is free. A clear goes straight to the final step.
// Reset (rst, synchronous): windows, running sums, accumulators, previous
//   means, slot and filled flag go to zero; gains take their default values.
// Stall: a held result keeps m_axis_tvalid high; the next request then waits
//   in its final step and s_axis_tready stays low until the output frees.
`timescale 1ns / 1ps

module three_axis_pid_with_moving_average_unit #(
  parameter int WINDOW_DEPTH  = tpid_pkg::WINDOW_DEPTH_DEF,
  parameter int FRACTION_BITS = tpid_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [95:0]                       s_axis_tdata,  // x_error, y_error, rot_error
  input  logic [0:0]                        s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [95:0]                       m_axis_tdata,  // x_corr, y_corr, rot_corr
  output logic [0:0]                        m_axis_tuser,  // valid_res
  input  logic                              cfg_we,
  input  logic [tpid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpid_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AXES   = tpid_pkg::AXES;
  localparam int DW     = tpid_pkg::DATA_W;
  localparam int SLOT_W = $clog2(WINDOW_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MEAN  = 6'b000010,
    S_PROP  = 6'b000100,
    S_INTEG = 6'b001000,
    S_DERIV = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [SLOT_W-1:0]          slot;
  logic                       filled;
  logic                       item_valid;
  logic [tpid_pkg::CFG_W-1:0] gains [AXES];
  logic signed [DW-1:0]       corr [AXES];
  tpid_pkg::lane_ctrl_t       ctrl;

  logic out_free;
  logic accept;
  logic is_clear;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_clear      = (s_axis_tuser[0] == tpid_pkg::OP_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = is_clear ? S_DONE : S_MEAN;
        end
      end
      S_MEAN:  state_next = S_PROP;
      S_PROP:  state_next = S_INTEG;
      S_INTEG: state_next = S_DERIV;
      S_DERIV: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          if (accept) begin
            state_next = is_clear ? S_DONE : S_MEAN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load  = accept && !is_clear;
    ctrl.clear = accept && is_clear;
    ctrl.mean  = (state == S_MEAN);
    ctrl.prop  = (state == S_PROP);
    ctrl.integ = (state == S_INTEG);
    ctrl.deriv = (state == S_DERIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      slot   <= '0;
      filled <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        if (slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
          slot   <= '0;
          filled <= 1'b1;
        end else begin
          slot <= slot + SLOT_W'(1);
        end
      end
      if (ctrl.clear) begin
        filled <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_valid <= !is_clear && filled;
    end
  end

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains[0] <= tpid_pkg::GAINS_X_RESET;
      gains[1] <= tpid_pkg::GAINS_Y_RESET;
      gains[2] <= tpid_pkg::GAINS_ROT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tpid_pkg::REG_GAINS_X:   gains[0] <= cfg_data;
        tpid_pkg::REG_GAINS_Y:   gains[1] <= cfg_data;
        tpid_pkg::REG_GAINS_ROT: gains[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    tpid_lane #(
      .WINDOW_DEPTH  (WINDOW_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .slot  (slot),
      .err   (s_axis_tdata[a*DW +: DW]),
      .gains (gains[a]),
      .corr  (corr[a])
    );
  end

  // merge: gather lane corrections into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_axis_tuser[0] <= item_valid;
      m_axis_tdata    <= item_valid ? {corr[2], corr[1], corr[0]} : '0;
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> (state == S_MEAN))
    else $error("accepted sample did not start the mean step");

  a_clear_drops_filled: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> !filled)
    else $error("clear left the window marked filled");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW_DEPTH - 1))
    else $error("window slot out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("invalid result carries nonzero corrections");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the three-axis PID unit with moving-average input.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = tpid_pkg::WINDOW_DEPTH_DEF;
  localparam int FRAC = tpid_pkg::FRACTION_BITS_DEF;
  localparam longint RECIP = (longint'(1) << FRAC) / DEPTH;
  localparam logic [tpid_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;
  localparam logic [tpid_pkg::GAIN_W-1:0] GAIN_MAX = 20'h7ffff;
  localparam logic [tpid_pkg::GAIN_W-1:0] GAIN_MIN = 20'h80000;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 356;

  typedef struct packed {
    logic valid;
    logic [tpid_pkg::AXES-1:0][tpid_pkg::DATA_W-1:0] corr;
  } corr_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata;   // x_error, y_error, rot_error
  logic [0:0] s_axis_tuser;    // op
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [95:0] m_axis_tdata;   // x_corr, y_corr, rot_corr
  logic [0:0] m_axis_tuser;    // valid_res
  logic cfg_we;
  logic [tpid_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tpid_pkg::CFG_W-1:0] cfg_data;

  three_axis_pid_with_moving_average_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [tpid_pkg::CFG_W-1:0] gain_reg [tpid_pkg::AXES];
  logic signed [tpid_pkg::DATA_W-1:0] err_window [tpid_pkg::AXES][DEPTH];
  int window_pos;
  bit window_full;
  logic signed [tpid_pkg::DATA_W-1:0] err_integral [tpid_pkg::AXES];
  logic signed [tpid_pkg::DATA_W-1:0] last_mean [tpid_pkg::AXES];

  corr_result_t pending_corrections[$];
  corr_result_t head_corr;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int clears_sent = 0;
  int results_seen = 0;
  int valid_seen = 0;
  int quiet_cycles = 0;

  function automatic longint sat32(input longint v);
    if (v > longint'(32'sh7fff_ffff)) return longint'(32'sh7fff_ffff);
    if (v < -longint'(64'h8000_0000)) return -longint'(64'h8000_0000);
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic corr_result_t compute_corrections(input logic op, input logic [95:0] errs);
    corr_result_t res;
    logic signed [tpid_pkg::DATA_W-1:0] err;
    logic signed [tpid_pkg::GAIN_W-1:0] kp, ki, kd;
    longint sum, mean, diff, total;
    res = '0;
    if (op == tpid_pkg::OP_CLEAR) begin
      for (int a = 0; a < tpid_pkg::AXES; a++) begin
        err_integral[a] = '0;
        last_mean[a] = '0;
      end
      window_full = 1'b0;
    end else begin
      res.valid = window_full;
      for (int a = 0; a < tpid_pkg::AXES; a++) err_window[a][window_pos] = errs[32*a +: 32];
      for (int a = 0; a < tpid_pkg::AXES; a++) begin
        err = errs[32*a +: 32];
        sum = 0;
        for (int k = 0; k < DEPTH; k++) sum += longint'(err_window[a][k]);
        mean = sat32(fx_mul(sum, RECIP));
        if (window_full) begin
          kp = gain_reg[a][19:0];
          ki = gain_reg[a][39:20];
          kd = gain_reg[a][59:40];
          diff = mean - longint'(last_mean[a]);
          total = fx_mul(kp, mean) + fx_mul(ki, err_integral[a]) + fx_mul(kd, diff);
          res.corr[a] = 32'(sat32(total));
        end
        err_integral[a] = 32'(sat32(longint'(err_integral[a]) + longint'(err)));
        last_mean[a] = 32'(mean);
      end
      window_pos++;
      if (window_pos >= DEPTH) begin
        window_pos = 0;
        window_full = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_corrections.size() == 0) begin
        $error("result with no request pending: tuser %0d tdata %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        head_corr = pending_corrections.pop_front();
        if (head_corr.valid) valid_seen++;
        check_field("valid_res", head_corr.valid, m_axis_tuser[0]);
        check_field("x_correction", $signed(head_corr.corr[0]), $signed(m_axis_tdata[31:0]));
        check_field("y_correction", $signed(head_corr.corr[1]), $signed(m_axis_tdata[63:32]));
        check_field("rot_correction", $signed(head_corr.corr[2]), $signed(m_axis_tdata[95:64]));
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] r);
    logic [95:0] errs;
    errs = {r, y, x};
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = errs;
    s_axis_tuser = op;
    do @(posedge clk); while (!s_axis_tready);
    pending_corrections.push_back(compute_corrections(op, errs));
    requests_sent++;
    if (op == tpid_pkg::OP_CLEAR) clears_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
  endtask

  task automatic write_gains(input logic [tpid_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpid_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx <= tpid_pkg::REG_GAINS_ROT) gain_reg[idx] = val;
  endtask

  task automatic write_all_gains(input logic [tpid_pkg::CFG_W-1:0] gx,
                                 input logic [tpid_pkg::CFG_W-1:0] gy,
                                 input logic [tpid_pkg::CFG_W-1:0] gr);
    drain_results();
    write_gains(tpid_pkg::REG_GAINS_X, gx);
    write_gains(tpid_pkg::REG_GAINS_Y, gy);
    write_gains(tpid_pkg::REG_GAINS_ROT, gr);
  endtask

  task automatic write_default_gains();
    write_all_gains(tpid_pkg::GAINS_X_RESET, tpid_pkg::GAINS_Y_RESET,
                    tpid_pkg::GAINS_ROT_RESET);
  endtask

  // reset gains; first valid result arrives with the sixth sample
  task automatic test_window_fill();
    for (int i = 0; i < 6; i++) begin
      send_request(tpid_pkg::OP_SAMPLE, ONE * i, -(ONE * i) / 2, ONE >> i);
    end
  endtask

  // full-scale errors drive accumulator and output saturation
  task automatic test_error_extremes();
    repeat (3) send_request(tpid_pkg::OP_SAMPLE, POS_MAX, NEG_MIN, POS_MAX);
    repeat (3) send_request(tpid_pkg::OP_SAMPLE, NEG_MIN, POS_MAX, NEG_MIN);
    send_request(tpid_pkg::OP_SAMPLE, '0, '0, '0);
  endtask

  // clear ignores its errors, keeps the window and slot, drops the filled flag
  task automatic test_clear();
    send_request(tpid_pkg::OP_CLEAR, POS_MAX, NEG_MIN, ONE);
    send_request(tpid_pkg::OP_CLEAR, '0, '0, '0);
    for (int i = 0; i < 6; i++) begin
      send_request(tpid_pkg::OP_SAMPLE, ONE * (i + 3), -ONE * 2, 32'hffff_8000);
    end
  endtask

  function automatic logic [tpid_pkg::CFG_W-1:0] rand_gains(input bit modest);
    logic [63:0] raw;
    logic [tpid_pkg::CFG_W-1:0] g;
    raw = {$urandom, $urandom};
    g = raw[tpid_pkg::CFG_W-1:0];
    if (modest) begin
      for (int f = 0; f < 3; f++) begin
        g[20*f +: 20] = 20'($urandom_range(0, 2 * ONE)) - 20'(ONE);
      end
    end
    return g;
  endfunction

  task automatic test_gain_extremes();
    write_all_gains({3{GAIN_MAX}}, {3{GAIN_MAX}}, {3{GAIN_MAX}});
    send_request(tpid_pkg::OP_SAMPLE, POS_MAX, NEG_MIN, POS_MAX);
    send_request(tpid_pkg::OP_SAMPLE, NEG_MIN, POS_MAX, ONE);
    write_all_gains({3{GAIN_MIN}}, {3{GAIN_MIN}}, {3{GAIN_MIN}});
    send_request(tpid_pkg::OP_SAMPLE, POS_MAX, NEG_MIN, NEG_MIN);
    send_request(tpid_pkg::OP_SAMPLE, NEG_MIN, POS_MAX, ONE);
    write_all_gains('0, '1, '0);
    send_request(tpid_pkg::OP_SAMPLE, ONE, -ONE, POS_MAX);
    // index 3 has no register behind it
    drain_results();
    write_gains(REG_UNUSED, rand_gains(1'b0));
    send_request(tpid_pkg::OP_SAMPLE, -ONE, ONE, NEG_MIN);
    write_default_gains();
  endtask

  function automatic logic [31:0] rand_error();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    if (pick < 8) return $urandom;
    if (pick == 8) return POS_MAX;
    return NEG_MIN;
  endfunction

  task automatic test_random_traffic();
    int idle_set [4] = '{0, 76, 0, 22};
    int stall_set [4] = '{0, 0, 76, 22};
    logic op;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_all_gains(rand_gains(1'b0), rand_gains(1'b0), rand_gains(1'b0));
        1: write_all_gains(rand_gains(1'b1), rand_gains(1'b1), rand_gains(1'b1));
        2: write_default_gains();
        default: write_all_gains(rand_gains(1'($urandom_range(1))), rand_gains(1'b1),
                                 rand_gains(1'b0));
      endcase
      send_idle_pct = idle_set[p];
      recv_stall_pct = stall_set[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // halfway through phase 1 the sender holds off until every outstanding result is back
        if (p == 1 && i == PHASE_ITEMS / 2) drain_results();
        op = ($urandom_range(99) < 3) ? tpid_pkg::OP_CLEAR : tpid_pkg::OP_SAMPLE;
        send_request(op, rand_error(), rand_error(), rand_error());
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = tpid_pkg::OP_SAMPLE;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tpid_pkg::REG_GAINS_X;
    cfg_data = '0;
    gain_reg[0] = tpid_pkg::GAINS_X_RESET;
    gain_reg[1] = tpid_pkg::GAINS_Y_RESET;
    gain_reg[2] = tpid_pkg::GAINS_ROT_RESET;
    for (int a = 0; a < tpid_pkg::AXES; a++) begin
      for (int k = 0; k < DEPTH; k++) err_window[a][k] = '0;
      err_integral[a] = '0;
      last_mean[a] = '0;
    end
    window_pos = 0;
    window_full = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_window_fill();
    test_error_extremes();
    test_clear();
    test_gain_extremes();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests (%0d clears) over four backpressure phases and gain extremes;",
             requests_sent, clears_sent);
    $display("checked %0d results, %0d with computed corrections.", results_seen, valid_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tpid_pkg.sv
rtl/core/tpid_lane.sv
rtl/core/three_axis_pid_with_moving_average_unit.sv
tb/tb.sv
